// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants shared by the sensor creep compensation unit.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned STORE_DEPTH = 2048;
  localparam int unsigned ADDR_W      = 11;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned REG_IDX_W   = 2;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_UPDATE_INTERVAL = 2'd0;
  localparam reg_idx_t REG_DRIFT_LIMIT     = 2'd1;
  localparam reg_idx_t REG_FLOOR_LEVEL     = 2'd2;

  localparam level_t UPDATE_INTERVAL_RST = 8'd5;
  localparam level_t DRIFT_LIMIT_RST     = 8'd1;
  localparam level_t FLOOR_LEVEL_RST     = 8'd2;

  typedef struct packed {
    addr_t  cell_index;
    level_t raw_level;
    logic   frame_start;
  } sample_t;

  typedef struct packed {
    addr_t  out_cell_index;
    level_t display_level;
  } result_t;

  typedef struct packed {
    level_t stable;
    level_t creep;
  } cell_word_t;

  localparam int unsigned WORD_W = $bits(cell_word_t);

  typedef struct packed {
    level_t drift_limit;
    level_t floor_level;
  } calc_cfg_t;

  typedef struct packed {
    level_t     display_level;
    cell_word_t word_next;
  } calc_res_t;

endpackage

// ===== rtl/scc_if.sv =====
// ----------------------------------------------------------------------------
// scc_sample_if / scc_result_if
// Valid/ready channels carrying one sample item or one result item.
// ----------------------------------------------------------------------------
interface scc_sample_if;
  logic             valid;
  logic             ready;
  scc_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scc_result_if;
  logic             valid;
  logic             ready;
  scc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/scc_ram.sv =====
// ----------------------------------------------------------------------------
// scc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/scc_calc.sv =====
// ----------------------------------------------------------------------------
// scc_calc
// Per-cell creep update and compensated display value for one reading.
// ----------------------------------------------------------------------------
module scc_calc (
  input  scc_pkg::cell_word_t word,
  input  scc_pkg::level_t     raw_level,
  input  logic                update,
  input  scc_pkg::calc_cfg_t  cfg,
  output scc_pkg::calc_res_t  res
);

  scc_pkg::level_t diff;
  scc_pkg::level_t creep_upd;
  logic            raw_above;

  always_comb begin
    raw_above = raw_level > word.stable;
    diff      = raw_above ? raw_level - word.stable : word.stable - raw_level;
    creep_upd = word.creep;
    res.word_next = word;
    res.display_level = '0;
    if (raw_level < cfg.floor_level) begin
      res.word_next.creep = '0;
    end else begin
      if (update) begin
        if (diff <= cfg.drift_limit) begin
          creep_upd = raw_above ? word.creep + diff : word.creep - diff;
        end
        res.word_next.stable = raw_level;
      end
      res.display_level = (raw_level > creep_upd) ? raw_level - creep_upd : raw_level;
      res.word_next.creep = (raw_level < creep_upd) ? '0 : creep_upd;
    end
  end

endmodule

// ===== rtl/sensor_creep_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_creep_compensation_unit
// Pipeline: an accepted sample item is registered in the s1 stage, then its
// result in the result register; a stalled result channel holds it in s1.
// Throughput: one item per cycle while the result channel does not stall,
// set by one read and one write of the cell memory per item, with forwarding
// between neighboring items. Reset: registers take their reset values, then
// a sweep zeroes the cell memory; no sample item is taken during the sweep.
// ----------------------------------------------------------------------------
module sensor_creep_compensation_unit #(
  parameter int ROWS    = 32,
  parameter int COLUMNS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  scc_sample_if.sink                sample,
  scc_result_if.source              result,
  input  logic                      wr_en,
  input  scc_pkg::reg_idx_t         wr_index,
  input  scc_pkg::level_t           wr_data
);

  localparam int unsigned CELLS = ROWS * COLUMNS;

  scc_pkg::level_t update_interval;
  scc_pkg::level_t drift_limit;
  scc_pkg::level_t floor_level;
  scc_pkg::level_t frame_phase;
  scc_pkg::level_t frame_phase_next;
  logic [scc_pkg::LEVEL_W:0] phase_inc;

  logic            clr_active;
  scc_pkg::addr_t  clr_addr;

  logic            s1_valid;
  scc_pkg::addr_t  s1_idx;
  scc_pkg::level_t s1_raw;
  logic            s1_update;
  logic            s1_adv;
  logic            s1_in_range;

  logic                 fwd_valid;
  scc_pkg::addr_t       fwd_addr;
  scc_pkg::cell_word_t  fwd_word;

  logic                        accept;
  logic                        ram_we;
  scc_pkg::addr_t              ram_waddr;
  logic [scc_pkg::WORD_W-1:0]  ram_wdata;
  logic [scc_pkg::WORD_W-1:0]  ram_rdata;
  scc_pkg::cell_word_t         cur_word;
  scc_pkg::calc_cfg_t          calc_cfg;
  scc_pkg::calc_res_t          calc_res;

  assign accept       = sample.valid && sample.ready;
  assign s1_adv       = s1_valid && (!result.valid || result.ready);
  assign sample.ready = !clr_active && (!s1_valid || s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval <= scc_pkg::UPDATE_INTERVAL_RST;
      drift_limit     <= scc_pkg::DRIFT_LIMIT_RST;
      floor_level     <= scc_pkg::FLOOR_LEVEL_RST;
    end else if (wr_en) begin
      case (wr_index)
        scc_pkg::REG_UPDATE_INTERVAL: update_interval <= wr_data;
        scc_pkg::REG_DRIFT_LIMIT:     drift_limit     <= wr_data;
        scc_pkg::REG_FLOOR_LEVEL:     floor_level     <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_inc        = {1'b0, frame_phase} + 9'd1;
    frame_phase_next = frame_phase;
    if (sample.data.frame_start) begin
      frame_phase_next = (phase_inc >= {1'b0, update_interval}) ?
                         '0 : phase_inc[scc_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase <= '0;
      clr_active  <= 1'b1;
      clr_addr    <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == scc_pkg::addr_t'(scc_pkg::STORE_DEPTH - 1)) begin
          clr_active <= 1'b0;
        end
      end
      if (accept) begin
        frame_phase <= frame_phase_next;
        s1_valid    <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx    <= sample.data.cell_index;
      s1_raw    <= sample.data.raw_level;
      s1_update <= (frame_phase_next == '0);
    end
  end

  assign s1_in_range = 32'(s1_idx) < CELLS;
  assign cur_word    = (fwd_valid && fwd_addr == s1_idx) ?
                       fwd_word : scc_pkg::cell_word_t'(ram_rdata);
  assign calc_cfg.drift_limit = drift_limit;
  assign calc_cfg.floor_level = floor_level;

  scc_calc u_calc (
    .word      (cur_word),
    .raw_level (s1_raw),
    .update    (s1_update),
    .cfg       (calc_cfg),
    .res       (calc_res)
  );

  always_comb begin
    ram_we    = clr_active || (s1_adv && s1_in_range);
    ram_waddr = clr_active ? clr_addr : s1_idx;
    ram_wdata = clr_active ? '0 : calc_res.word_next;
  end

  scc_ram #(
    .WIDTH (scc_pkg::WORD_W),
    .DEPTH (scc_pkg::STORE_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (sample.data.cell_index),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_adv && s1_in_range) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_in_range) begin
      fwd_addr <= s1_idx;
      fwd_word <= calc_res.word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.data.out_cell_index <= s1_idx;
      result.data.display_level  <= s1_in_range ? calc_res.display_level : '0;
    end
  end

  a_clear_blocks_items: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s1_valid && !result.valid)
    else $error("item in flight during memory clear");

  a_display_not_above_raw: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> calc_res.display_level <= s1_raw)
    else $error("display level above raw reading");

  a_floor_clears_creep: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_raw < floor_level |-> calc_res.word_next.creep == '0
                                         && calc_res.display_level == '0)
    else $error("reading below floor did not clear creep");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    ram_we && !clr_active |-> s1_adv && s1_in_range)
    else $error("cell memory written without an advancing item");

endmodule
